// ----- src/mva_pkg.sv -----
`timescale 1ns / 1ps
// mva_pkg: shared sizes, action codes and handshake structs for the vertex
// normal accumulator. No dependencies.
package mva_pkg;

	localparam int VERTEX_SLOTS    = 4096;
	localparam int SLOT_BITS       = $clog2(VERTEX_SLOTS);
	localparam int SLOT_FIELD_BITS = 12;
	localparam int COORD_BITS      = 24;
	localparam int EDGE_BITS       = COORD_BITS + 1;
	localparam int PROD_BITS       = 2 * EDGE_BITS;
	localparam int CROSS_BITS      = PROD_BITS + 2;
	localparam int SUM_BITS        = 24;
	localparam int Q_BITS          = 16;
	localparam int NV_BITS         = CROSS_BITS;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_TRI  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	typedef struct packed {
		logic start;
	} norm_ctl_t;

	typedef struct packed {
		logic done;
		logic zero;
	} norm_stat_t;

endpackage

// ----- src/mva_norm.sv -----
`timescale 1ns / 1ps
// mva_norm: iterative unit-vector unit (bit shift, squares, square root,
// restoring divide) giving Q1.15 components. Depends on mva_pkg.
module mva_norm import mva_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  norm_ctl_t                 ctl,
	input  logic signed [NV_BITS-1:0] vec_x,
	input  logic signed [NV_BITS-1:0] vec_y,
	input  logic signed [NV_BITS-1:0] vec_z,
	output norm_stat_t                stat,
	output logic signed [Q_BITS-1:0]  q_x,
	output logic signed [Q_BITS-1:0]  q_y,
	output logic signed [Q_BITS-1:0]  q_z
);

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_SQRT  = 3'd3;
	localparam logic [2:0] N_DIVI  = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;

	localparam int M_BITS   = 31;
	localparam int SQ_BITS  = 2 * M_BITS;
	localparam int RAD_BITS = 64;
	localparam int ROOT_BITS = 32;
	localparam int QUO_BITS = 17;
	localparam int REM_BITS = M_BITS + 15 + 2;
	localparam logic [QUO_BITS-1:0] Q_MAX = QUO_BITS'(32767);

	logic [2:0]              state_q;
	logic [1:0]              idx_q;
	logic [4:0]              cnt_q;
	logic                    done_q;
	logic                    zero_q;

	logic [NV_BITS-1:0]      m_q [3];
	logic                    neg_q [3];
	logic [SQ_BITS-1:0]      prod_q;
	logic [RAD_BITS-1:0]     acc_q;
	logic [RAD_BITS-1:0]     rad_q;
	logic [RAD_BITS-1:0]     res_q;
	logic [RAD_BITS-1:0]     bit_q;
	logic [REM_BITS-1:0]     rem_q;
	logic [REM_BITS-1:0]     dvs_q;
	logic [QUO_BITS-1:0]     quo_q;
	logic signed [Q_BITS-1:0] qo_q [3];

	logic [NV_BITS-1:0]      mag_in [3];
	logic                    in_zero;
	logic                    hi_any;
	logic                    lo_all;
	logic [M_BITS-1:0]       msel;
	logic [RAD_BITS:0]       trial;
	logic                    sq_ge;
	logic                    div_ge;
	logic [QUO_BITS-1:0]     quo_next;
	logic [Q_BITS-2:0]       cap;
	logic [ROOT_BITS-1:0]    root;

	function automatic logic [NV_BITS-1:0] mag(input logic signed [NV_BITS-1:0] v);
		mag = v[NV_BITS-1] ? NV_BITS'(-v) : NV_BITS'(v);
	endfunction

	always_comb begin
		mag_in[0] = mag(vec_x);
		mag_in[1] = mag(vec_y);
		mag_in[2] = mag(vec_z);
		in_zero   = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
		// largest magnitude must land in [2^30, 2^31)
		hi_any = (|m_q[0][NV_BITS-1:M_BITS]) | (|m_q[1][NV_BITS-1:M_BITS])
		       | (|m_q[2][NV_BITS-1:M_BITS]);
		lo_all = ~((|m_q[0][NV_BITS-1:M_BITS-1]) | (|m_q[1][NV_BITS-1:M_BITS-1])
		       | (|m_q[2][NV_BITS-1:M_BITS-1]));
		case (idx_q)
			2'd0:    msel = m_q[0][M_BITS-1:0];
			2'd1:    msel = m_q[1][M_BITS-1:0];
			default: msel = m_q[2][M_BITS-1:0];
		endcase
		trial    = {1'b0, res_q} + {1'b0, bit_q};
		sq_ge    = {1'b0, rad_q} >= trial;
		div_ge   = rem_q >= dvs_q;
		quo_next = {quo_q[QUO_BITS-2:0], div_ge};
		cap      = (quo_next > Q_MAX) ? Q_MAX[Q_BITS-2:0] : quo_next[Q_BITS-2:0];
		root     = res_q[ROOT_BITS-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (ctl.start) begin
						zero_q <= in_zero;
						if (in_zero) begin
							done_q <= 1'b1;
						end else begin
							state_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					if (!hi_any && !lo_all) begin
						idx_q   <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					if (bit_q[0]) begin
						idx_q   <= '0;
						state_q <= N_DIVI;
					end
				end
				N_DIVI: begin
					cnt_q   <= 5'(QUO_BITS - 1);
					state_q <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						if (idx_q == 2'd2) begin
							done_q  <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= N_DIVI;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (ctl.start) begin
					m_q[0]   <= mag_in[0];
					m_q[1]   <= mag_in[1];
					m_q[2]   <= mag_in[2];
					neg_q[0] <= vec_x[NV_BITS-1];
					neg_q[1] <= vec_y[NV_BITS-1];
					neg_q[2] <= vec_z[NV_BITS-1];
					acc_q    <= '0;
					if (in_zero) begin
						qo_q[0] <= '0;
						qo_q[1] <= '0;
						qo_q[2] <= '0;
					end
				end
			end
			N_SHIFT: begin
				if (hi_any) begin
					m_q[0] <= m_q[0] >> 1;
					m_q[1] <= m_q[1] >> 1;
					m_q[2] <= m_q[2] >> 1;
				end else if (lo_all) begin
					m_q[0] <= m_q[0] << 1;
					m_q[1] <= m_q[1] << 1;
					m_q[2] <= m_q[2] << 1;
				end
			end
			N_SQ: begin
				prod_q <= msel * msel;
				if (idx_q != 2'd0) begin
					acc_q <= acc_q + RAD_BITS'(prod_q);
				end
				if (idx_q == 2'd3) begin
					rad_q <= acc_q + RAD_BITS'(prod_q);
					res_q <= '0;
					bit_q <= RAD_BITS'(1) << (RAD_BITS - 2);
				end
			end
			N_SQRT: begin
				if (sq_ge) begin
					rad_q <= rad_q - trial[RAD_BITS-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIVI: begin
				rem_q <= REM_BITS'({msel, 15'b0}) + REM_BITS'(root >> 1);
				dvs_q <= REM_BITS'({root, 16'b0});
				quo_q <= '0;
			end
			N_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dvs_q;
				end
				dvs_q <= dvs_q >> 1;
				quo_q <= quo_next;
				if (cnt_q == '0) begin
					case (idx_q)
						2'd0:    qo_q[0] <= neg_q[0] ? -Q_BITS'(cap) : Q_BITS'(cap);
						2'd1:    qo_q[1] <= neg_q[1] ? -Q_BITS'(cap) : Q_BITS'(cap);
						default: qo_q[2] <= neg_q[2] ? -Q_BITS'(cap) : Q_BITS'(cap);
					endcase
				end
			end
			default: ;
		endcase
	end

	assign stat.done = done_q;
	assign stat.zero = zero_q;
	assign q_x = qo_q[0];
	assign q_y = qo_q[1];
	assign q_z = qo_q[2];

endmodule

// ----- src/mesh_vertex_normal_accumulator.sv -----
`timescale 1ns / 1ps
// mesh_vertex_normal_accumulator: top level with vertex and normal-sum
// memories and the item sequencer. Depends on mva_pkg and mva_norm.
//
// Block keeps a vertex position store and a per-slot sum of face normals.
// A load word writes a vertex and zeroes its sum. A triangle word fetches
// its three corners, crosses the edges p2-p0 and p1-p0 on one shared 25x25
// multiplier, turns the result into a Q1.15 unit normal on the shared
// normalising unit and then read-modify-writes the three corner sums (add
// with saturation when smooth_mode is 1, overwrite when 0). A read word
// normalises one slot's sum and returns one result word; no_normal flags
// a zero sum. On a non-zero vector the normalising unit runs an alignment
// shift of one bit per cycle, a 32-step square root and three 17-step
// divides. One word is in work at a time; in_ready is low meanwhile. A
// finished result sits in the output register while the next word is taken.
// After reset a clearing pass zeroes all 4096 slots of the sum memory, one
// slot a cycle, with in_ready low; smooth_mode may be written throughout.
// Vertex slots never loaded read as undefined. Action 3 is dropped.
module mesh_vertex_normal_accumulator import mva_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic [SLOT_FIELD_BITS-1:0]   vertex_slot,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	input  logic [SLOT_FIELD_BITS-1:0]   corner_a,
	input  logic [SLOT_FIELD_BITS-1:0]   corner_b,
	input  logic [SLOT_FIELD_BITS-1:0]   corner_c,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [Q_BITS-1:0]     normal_x,
	output logic signed [Q_BITS-1:0]     normal_y,
	output logic signed [Q_BITS-1:0]     normal_z,
	output logic                         no_normal
);

	localparam logic [4:0] S_CLEAR   = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_RD_ADDR = 5'd2;
	localparam logic [4:0] S_RD_DATA = 5'd3;
	localparam logic [4:0] S_RD_NORM = 5'd4;
	localparam logic [4:0] S_RD_OUT  = 5'd5;
	localparam logic [4:0] S_T_A     = 5'd6;
	localparam logic [4:0] S_T_B     = 5'd7;
	localparam logic [4:0] S_T_C     = 5'd8;
	localparam logic [4:0] S_T_D     = 5'd9;
	localparam logic [4:0] S_T_EDGE  = 5'd10;
	localparam logic [4:0] S_T_MUL   = 5'd11;
	localparam logic [4:0] S_T_ACC   = 5'd12;
	localparam logic [4:0] S_T_NST   = 5'd13;
	localparam logic [4:0] S_T_NORM  = 5'd14;
	localparam logic [4:0] S_T_URD   = 5'd15;
	localparam logic [4:0] S_T_UWR   = 5'd16;

	localparam int VW = 3 * COORD_BITS;
	localparam int SW = 3 * SUM_BITS;
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(VERTEX_SLOTS - 1);

	// memories
	logic [VW-1:0] vmem_q [VERTEX_SLOTS];
	logic [SW-1:0] smem_q [VERTEX_SLOTS];
	logic [VW-1:0] vrd_q;
	logic [SW-1:0] srd_q;

	// control
	logic [4:0]           state_q;
	logic [SLOT_BITS-1:0] clr_q;
	logic [2:0]           k_q;
	logic [1:0]           ui_q;
	logic                 smooth_q;
	logic                 out_valid_q;

	// payload
	logic [SLOT_BITS-1:0]          slot_q;
	logic                          rd_ok_q;
	logic [SLOT_BITS-1:0]          cnr_q [3];
	logic [VW-1:0]                 p0_q, p1_q, p2_q;
	logic signed [EDGE_BITS-1:0]   e_q [6];
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [CROSS_BITS-1:0]  n_q [3];
	logic signed [Q_BITS-1:0]      nx_q, ny_q, nz_q;
	logic                          nn_q;

	logic                          accept;
	logic                          slot_ok;
	logic                          tri_ok;
	logic [SLOT_BITS-1:0]          vaddr;
	logic [SLOT_BITS-1:0]          saddr;
	logic                          swe;
	logic [SW-1:0]                 swdata;
	logic [SLOT_BITS-1:0]          ucnr;
	logic signed [EDGE_BITS-1:0]   ma, mb;
	norm_ctl_t                     nctl;
	norm_stat_t                    nstat;
	logic signed [NV_BITS-1:0]     nv_x, nv_y, nv_z;
	logic signed [Q_BITS-1:0]      fq_x, fq_y, fq_z;

	function automatic logic slot_in_range(input logic [SLOT_FIELD_BITS-1:0] s);
		slot_in_range = {1'b0, s} < (SLOT_FIELD_BITS + 1)'(VERTEX_SLOTS);
	endfunction

	function automatic logic signed [EDGE_BITS-1:0] ediff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b);
		ediff = EDGE_BITS'(a) - EDGE_BITS'(b);
	endfunction

	function automatic logic signed [SUM_BITS-1:0] sat_add(
		input logic signed [SUM_BITS-1:0] a,
		input logic signed [Q_BITS-1:0]   b);
		logic signed [SUM_BITS:0] s;
		s = (SUM_BITS + 1)'(a) + (SUM_BITS + 1)'(b);
		if (s[SUM_BITS] != s[SUM_BITS-1]) begin
			sat_add = s[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
			                      : {1'b0, {(SUM_BITS - 1){1'b1}}};
		end else begin
			sat_add = s[SUM_BITS-1:0];
		end
	endfunction

	function automatic logic signed [NV_BITS-1:0] sum_ext(input logic [SUM_BITS-1:0] s);
		sum_ext = NV_BITS'(signed'(s));
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign slot_ok  = slot_in_range(vertex_slot);
	assign tri_ok   = slot_in_range(corner_a) && slot_in_range(corner_b)
	               && slot_in_range(corner_c);
	assign ucnr     = cnr_q[ui_q];

	// memory port steering
	always_comb begin
		case (state_q)
			S_T_A:   vaddr = cnr_q[0];
			S_T_B:   vaddr = cnr_q[1];
			default: vaddr = cnr_q[2];
		endcase
		swe    = 1'b0;
		swdata = '0;
		case (state_q)
			S_CLEAR: begin
				saddr = clr_q;
				swe   = 1'b1;
			end
			S_IDLE: begin
				saddr = SLOT_BITS'(vertex_slot);
				swe   = accept && (action == ACT_LOAD) && slot_ok;
			end
			S_RD_ADDR: saddr = slot_q;
			S_T_UWR: begin
				saddr = ucnr;
				swe   = 1'b1;
				if (smooth_q) begin
					swdata = {sat_add(srd_q[3*SUM_BITS-1:2*SUM_BITS], fq_x),
					          sat_add(srd_q[2*SUM_BITS-1:SUM_BITS], fq_y),
					          sat_add(srd_q[SUM_BITS-1:0], fq_z)};
				end else begin
					swdata = {SUM_BITS'(fq_x), SUM_BITS'(fq_y), SUM_BITS'(fq_z)};
				end
			end
			default: saddr = ucnr;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && (action == ACT_LOAD) && slot_ok) begin
			vmem_q[SLOT_BITS'(vertex_slot)] <= {coord_x, coord_y, coord_z};
		end
		vrd_q <= vmem_q[vaddr];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			smem_q[saddr] <= swdata;
		end
		srd_q <= smem_q[saddr];
	end

	// operand pairs for n = e1 x e2 style products, one per step
	always_comb begin
		case (k_q)
			3'd0:    begin ma = e_q[1]; mb = e_q[5]; end
			3'd1:    begin ma = e_q[2]; mb = e_q[4]; end
			3'd2:    begin ma = e_q[2]; mb = e_q[3]; end
			3'd3:    begin ma = e_q[0]; mb = e_q[5]; end
			3'd4:    begin ma = e_q[0]; mb = e_q[4]; end
			default: begin ma = e_q[1]; mb = e_q[3]; end
		endcase
	end

	always_comb begin
		nctl.start = (state_q == S_RD_DATA) || (state_q == S_T_NST);
		if (state_q == S_RD_DATA) begin
			nv_x = rd_ok_q ? sum_ext(srd_q[3*SUM_BITS-1:2*SUM_BITS]) : '0;
			nv_y = rd_ok_q ? sum_ext(srd_q[2*SUM_BITS-1:SUM_BITS]) : '0;
			nv_z = rd_ok_q ? sum_ext(srd_q[SUM_BITS-1:0]) : '0;
		end else begin
			nv_x = n_q[0];
			nv_y = n_q[1];
			nv_z = n_q[2];
		end
	end

	mva_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (nctl),
		.vec_x  (nv_x),
		.vec_y  (nv_y),
		.vec_z  (nv_z),
		.stat   (nstat),
		.q_x    (fq_x),
		.q_y    (fq_y),
		.q_z    (fq_z)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			ui_q        <= '0;
			smooth_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				smooth_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_BITS'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_READ) begin
							state_q <= S_RD_ADDR;
						end else if ((action == ACT_TRI) && tri_ok) begin
							state_q <= S_T_A;
						end
					end
				end
				S_RD_ADDR: state_q <= S_RD_DATA;
				S_RD_DATA: state_q <= S_RD_NORM;
				S_RD_NORM: begin
					if (nstat.done) begin
						state_q <= S_RD_OUT;
					end
				end
				S_RD_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_T_A: state_q <= S_T_B;
				S_T_B: state_q <= S_T_C;
				S_T_C: state_q <= S_T_D;
				S_T_D: state_q <= S_T_EDGE;
				S_T_EDGE: begin
					k_q     <= '0;
					state_q <= S_T_MUL;
				end
				S_T_MUL: state_q <= S_T_ACC;
				S_T_ACC: begin
					k_q <= k_q + 3'd1;
					state_q <= (k_q == 3'd5) ? S_T_NST : S_T_MUL;
				end
				S_T_NST: state_q <= S_T_NORM;
				S_T_NORM: begin
					if (nstat.done) begin
						ui_q    <= '0;
						state_q <= S_T_URD;
					end
				end
				S_T_URD: state_q <= S_T_UWR;
				S_T_UWR: begin
					ui_q <= ui_q + 2'd1;
					state_q <= (ui_q == 2'd2) ? S_IDLE : S_T_URD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q   <= SLOT_BITS'(vertex_slot);
			rd_ok_q  <= slot_ok;
			cnr_q[0] <= SLOT_BITS'(corner_a);
			cnr_q[1] <= SLOT_BITS'(corner_b);
			cnr_q[2] <= SLOT_BITS'(corner_c);
		end
		case (state_q)
			S_T_B: p0_q <= vrd_q;
			S_T_C: p1_q <= vrd_q;
			S_T_D: p2_q <= vrd_q;
			S_T_EDGE: begin
				e_q[0] <= ediff(p2_q[3*COORD_BITS-1:2*COORD_BITS],
				                p0_q[3*COORD_BITS-1:2*COORD_BITS]);
				e_q[1] <= ediff(p2_q[2*COORD_BITS-1:COORD_BITS],
				                p0_q[2*COORD_BITS-1:COORD_BITS]);
				e_q[2] <= ediff(p2_q[COORD_BITS-1:0], p0_q[COORD_BITS-1:0]);
				e_q[3] <= ediff(p1_q[3*COORD_BITS-1:2*COORD_BITS],
				                p0_q[3*COORD_BITS-1:2*COORD_BITS]);
				e_q[4] <= ediff(p1_q[2*COORD_BITS-1:COORD_BITS],
				                p0_q[2*COORD_BITS-1:COORD_BITS]);
				e_q[5] <= ediff(p1_q[COORD_BITS-1:0], p0_q[COORD_BITS-1:0]);
			end
			S_T_MUL: prod_q <= ma * mb;
			S_T_ACC: begin
				// even step loads, odd step subtracts
				case (k_q)
					3'd0:    n_q[0] <= CROSS_BITS'(prod_q);
					3'd1:    n_q[0] <= n_q[0] - CROSS_BITS'(prod_q);
					3'd2:    n_q[1] <= CROSS_BITS'(prod_q);
					3'd3:    n_q[1] <= n_q[1] - CROSS_BITS'(prod_q);
					3'd4:    n_q[2] <= CROSS_BITS'(prod_q);
					default: n_q[2] <= n_q[2] - CROSS_BITS'(prod_q);
				endcase
			end
			S_RD_OUT: begin
				if (!out_valid_q) begin
					nx_q <= fq_x;
					ny_q <= fq_y;
					nz_q <= fq_z;
					nn_q <= nstat.zero;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign normal_x  = nx_q;
	assign normal_y  = ny_q;
	assign normal_z  = nz_q;
	assign no_normal = nn_q;

	a_tri_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_TRI)) |=> !in_ready)
		else $error("triangle word did not hold off input");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_RD_OUT))
		else $error("result word raised outside read completion");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_normal) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("flagged result carries a non-zero normal");

	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		nstat.done |-> (state_q == S_RD_NORM || state_q == S_T_NORM))
		else $error("normaliser finished with nobody waiting");

endmodule
